@@ src/bksc_pkg.sv @@
// Shared types and constants of the block keyed byte shift codec.
`default_nettype none
package bksc_pkg;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// Low byte of the rounds value used when the rounds register is zero.
	localparam logic [31:0] DEFAULT_ROUNDS = 32'd1;

	localparam logic [7:0]  BLK_LEN_RST    = 8'd1;
	localparam logic [4:0]  KEY_LENGTH_RST = 5'd1;
	localparam logic [31:0] ROUNDS_RST     = 32'd0;
	localparam logic        DIRECTION_RST  = 1'b0;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_KEY  = 1'b1;
	localparam logic DIR_ENC   = 1'b0;
	localparam logic DIR_DEC   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLK_LEN    = 2'd0,
		REG_KEY_LENGTH = 2'd1,
		REG_ROUNDS     = 2'd2,
		REG_DIRECTION  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  blk_len;
		logic [4:0]  key_length;
		logic [31:0] rounds;
		logic        direction;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] key_index;
		logic [7:0] key_value;
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       mult_forced;
	} out_item_t;

endpackage
`default_nettype wire

@@ src/bksc_cfg_regs.sv @@
// Configuration register file of the block keyed byte shift codec.
`default_nettype none
module bksc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bksc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bksc_pkg::CFG_DATA_W-1:0] cfg_data,
	output bksc_pkg::cfg_t                       cfg
);

	bksc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blk_len    <= bksc_pkg::BLK_LEN_RST;
			cfg_q.key_length <= bksc_pkg::KEY_LENGTH_RST;
			cfg_q.rounds     <= bksc_pkg::ROUNDS_RST;
			cfg_q.direction  <= bksc_pkg::DIRECTION_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bksc_pkg::REG_BLK_LEN:    cfg_q.blk_len    <= cfg_data[7:0];
				bksc_pkg::REG_KEY_LENGTH: cfg_q.key_length <= cfg_data[4:0];
				bksc_pkg::REG_ROUNDS:     cfg_q.rounds     <= cfg_data[31:0];
				bksc_pkg::REG_DIRECTION:  cfg_q.direction  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ src/bksc_core.sv @@
// Key table, block and key position counters, and the per-byte shift datapath.
`default_nettype none
module bksc_core #(
	parameter int unsigned KEY_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire bksc_pkg::in_item_t item,
	input  wire bksc_pkg::cfg_t     cfg,
	output bksc_pkg::out_item_t     result
);

	// Only 4-bit indexes ever reach the table.
	localparam int unsigned TBL_DEPTH = (KEY_DEPTH < 16) ? KEY_DEPTH : 16;
	localparam int unsigned TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam logic [7:0]  KDEPTH8   = 8'(KEY_DEPTH);

	logic [7:0] key_table_q [TBL_DEPTH];
	logic [7:0] byte_in_block_q;
	logic [3:0] key_pos_q;

	logic [7:0]  klen;
	logic [7:0]  bsize;
	logic [3:0]  pos;
	logic [7:0]  mult;
	logic        clamped;
	logic [7:0]  key_byte;
	logic [15:0] product;
	logic [7:0]  shift;
	logic [8:0]  cnt;
	logic [4:0]  pos_inc;
	logic [7:0]  bib_nxt;
	logic [3:0]  pos_nxt;

	always_comb begin
		klen = (cfg.key_length == 5'd0) ? 8'd1 : {3'b000, cfg.key_length};
		if (klen > KDEPTH8) klen = KDEPTH8;
		bsize = (cfg.blk_len == 8'd0) ? 8'd1 : cfg.blk_len;

		pos = ({4'b0000, key_pos_q} >= klen) ? 4'd0 : key_pos_q;

		mult = (cfg.rounds == 32'd0) ? bksc_pkg::DEFAULT_ROUNDS[7:0] : cfg.rounds[7:0];
		clamped = (mult == 8'd0);
		if (clamped) mult = 8'd1;

		key_byte = key_table_q[pos[TBL_AW-1:0]];
		product  = key_byte * mult;
		shift    = product[7:0];

		result.out_byte = (cfg.direction == bksc_pkg::DIR_DEC) ? item.data_byte - shift
		                                                       : item.data_byte + shift;
		result.out_last    = item.last;
		result.mult_forced = clamped;

		cnt     = {1'b0, byte_in_block_q} + 9'd1;
		pos_inc = {1'b0, pos} + 5'd1;
		if (item.last) begin
			bib_nxt = 8'd0;
			pos_nxt = 4'd0;
		end else if (cnt >= {1'b0, bsize}) begin
			bib_nxt = 8'd0;
			pos_nxt = ({3'b000, pos_inc} >= klen) ? 4'd0 : pos_inc[3:0];
		end else begin
			bib_nxt = cnt[7:0];
			pos_nxt = pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_block_q <= 8'd0;
			key_pos_q       <= 4'd0;
		end else if (fire && item.kind == bksc_pkg::KIND_DATA) begin
			byte_in_block_q <= bib_nxt;
			key_pos_q       <= pos_nxt;
		end
	end

	// Table contents are undefined until written: no reset.
	always_ff @(posedge clk) begin
		if (fire && item.kind == bksc_pkg::KIND_KEY &&
		    {4'b0000, item.key_index} < KDEPTH8) begin
			key_table_q[item.key_index[TBL_AW-1:0]] <= item.key_value;
		end
	end

endmodule
`default_nettype wire

@@ src/block_keyed_byte_shift_codec_unit.sv @@
// Top level of the block keyed byte shift codec: stream ports, input and result registers.
// Usage:
//  - Items enter on the s_ stream: s_tuser is the kind (0 data byte, 1 key table write),
//    s_tlast marks the final byte of a message, s_tdata carries index, key and data.
//  - Each data byte yields one result item on the m_ stream; key writes yield none.
//  - Configuration (block size, key length, rounds, direction) is written through
//    cfg_we / cfg_index / cfg_data while no item is in flight.
// Path: an accepted data byte waits in the input register until it fires; the core
//   then loads its result into the result register, which drives m_tvalid until
//   the receiver takes it.
// Throughput: one item per cycle unless the receiver stalls, set by the single input
//   register feeding table read, 8x8 multiply and add/subtract before the result register.
// Key writes take effect for the very next data byte.
// Reset clears both positions and all valid flags and returns the configuration to
//   its reset values; key table entries stay undefined until written.
// When the receiver stalls, the result register holds; the input register still
//   takes one item, and a key write in it proceeds since it needs no output slot.
`default_nettype none
module block_keyed_byte_shift_codec_unit #(
	parameter int unsigned KEY_DEPTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tdata: key_index[3:0], key_value[11:4], data_byte[19:12], zero pad[23:20]
	input  wire logic [bksc_pkg::IN_DATA_W-1:0]  s_tdata,
	// s_tuser: kind[0]
	input  wire logic                            s_tuser,
	input  wire logic                            s_tlast,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// m_tdata: out_byte[7:0]
	output logic [bksc_pkg::OUT_DATA_W-1:0]      m_tdata,
	// m_tuser: multiplier forced to one [0]
	output logic                                 m_tuser,
	output logic                                 m_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic                            cfg_we,
	input  wire logic [bksc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bksc_pkg::CFG_DATA_W-1:0] cfg_data
);

	bksc_pkg::cfg_t      cfg;
	bksc_pkg::in_item_t  item_s1;
	bksc_pkg::out_item_t res_comb;
	bksc_pkg::out_item_t res_s2;
	logic                valid_s1;
	logic                valid_s2;
	logic                out_free;
	logic                fire;

	// Output slot is free when empty or being drained this cycle.
	assign out_free = !valid_s2 || m_tready;
	// Key writes leave the input register without needing the output slot.
	assign fire     = valid_s1 && (item_s1.kind == bksc_pkg::KIND_KEY || out_free);
	assign s_tready = !valid_s1 || fire;

	bksc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bksc_core #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_comb)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind      <= s_tuser;
			item_s1.key_index <= s_tdata[3:0];
			item_s1.key_value <= s_tdata[11:4];
			item_s1.data_byte <= s_tdata[19:12];
			item_s1.last      <= s_tlast;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= fire && item_s1.kind == bksc_pkg::KIND_DATA;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && item_s1.kind == bksc_pkg::KIND_DATA) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.out_byte;
	assign m_tlast  = res_s2.out_last;
	assign m_tuser  = res_s2.mult_forced;

endmodule
`default_nettype wire
